// ===== src/tfn_pkg.sv =====
// Shared constants and widths for the triangle face normal engine.
package tfn_pkg;

  localparam int unsigned VertexCount = 1024;
  localparam int unsigned IdxW        = $clog2(VertexCount);
  localparam int unsigned PosW        = 16;
  localparam int unsigned FracW       = 14;
  localparam int unsigned NrmW        = 16;
  localparam int unsigned OpW         = 2;

  // edge = difference of two positions, magnitude fits PosW bits
  localparam int unsigned EdgeW  = PosW + 1;
  localparam int unsigned EmagW  = PosW;
  // cross product component: sum of two products of edge magnitudes, signed
  localparam int unsigned CrossW = 2 * EmagW + 3;
  localparam int unsigned CmagW  = CrossW - 1;
  // components are scaled down below 2^31 before squaring
  localparam int unsigned MagW   = 31;
  localparam int unsigned MulW   = MagW;
  localparam int unsigned SumW   = 2 * MagW + 2;
  localparam int unsigned RootW  = SumW / 2;
  localparam int unsigned NumW   = MagW + FracW + 1;
  localparam int unsigned QuotW  = FracW + 1;
  localparam int unsigned ShW    = $clog2(CmagW - MagW + 1);

  localparam logic [OpW-1:0] OpWrite = 2'd0;
  localparam logic [OpW-1:0] OpTri   = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;

endpackage

// ===== src/tfn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tfn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tfn_mul.sv =====
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
module tfn_mul import tfn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MulW-1:0]     a_i,
  input  logic [MulW-1:0]     b_i,
  output logic                done_o,
  output logic [2*MulW-1:0]   prod_o
);

  localparam int unsigned CntW = $clog2(MulW + 1);

  logic [2*MulW-1:0] p_q, p_d;
  logic [MulW-1:0]   m_q, m_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [MulW:0]     sum;

  always_comb begin
    sum    = {1'b0, p_q[2*MulW-1:MulW]} + (p_q[0] ? {1'b0, m_q} : '0);
    p_d    = p_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d    = {{MulW{1'b0}}, b_i};
      m_d    = a_i;
      cnt_d  = CntW'(MulW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {sum, p_q[MulW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    m_q <= m_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ===== src/tfn_sqrt.sv =====
// Digit-by-digit floor square root, two radicand bits per cycle.
module tfn_sqrt import tfn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [SumW-1:0]  s_q, s_d;
  logic [RootW:0]   r_q, r_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RootW+2:0] rp, trial, diff;

  always_comb begin
    rp     = {r_q, s_q[SumW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rp - trial;
    s_d    = s_q;
    r_d    = r_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      s_d    = rad_i;
      r_d    = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      s_d   = s_q << 2;
      cnt_d = cnt_q - 1'b1;
      if (rp >= trial) begin
        r_d    = diff[RootW:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        r_d    = rp[RootW:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    r_q    <= r_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/tfn_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit QuotW bits.
module tfn_div import tfn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [RootW-1:0] den_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [RootW-1:0] r_q, r_d;
  logic [RootW-1:0] den_q, den_d;
  logic [QuotW-1:0] n_q, n_d;
  logic [QuotW-1:0] q_q, q_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RootW:0]   rp, diff;
  logic [NumW-1:0]  num_hi;

  always_comb begin
    rp     = {r_q, n_q[QuotW-1]};
    diff   = rp - {1'b0, den_q};
    num_hi = num_i >> QuotW;
    r_d    = r_q;
    den_d  = den_q;
    n_d    = n_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // upper part is already below the divisor
      r_d    = num_hi[RootW-1:0];
      n_d    = num_i[QuotW-1:0];
      den_d  = den_i;
      q_d    = '0;
      cnt_d  = CntW'(QuotW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d   = n_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (rp >= {1'b0, den_q}) begin
        r_d = diff[RootW-1:0];
        q_d = {q_q[QuotW-2:0], 1'b1};
      end else begin
        r_d = rp[RootW-1:0];
        q_d = {q_q[QuotW-2:0], 1'b0};
      end
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    den_q <= den_d;
    n_q   <= n_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== src/triangle_face_normal_engine.sv =====
// Triangle face normal engine: position store, serial cross product and normalization.
//
// After reset the block clears its normal store, one entry per cycle, for all 1024 entries,
// and accepts no item until then. A triangle item runs three position reads, nine
// products on one bit-serial multiplier (six for the cross product, three for the
// squared length), a 32-step square root, three 15-step divides and three normal
// store writes; a zero cross product skips the squares, root and divides. Most of
// a triangle item's time goes to the multiplier. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module triangle_face_normal_engine import tfn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OpW-1:0]         operation_i,
  input  logic [IdxW-1:0]        corner0_index_i,
  input  logic [IdxW-1:0]        corner1_index_i,
  input  logic [IdxW-1:0]        corner2_index_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [NrmW-1:0] normal_x_o,
  output logic signed [NrmW-1:0] normal_y_o,
  output logic signed [NrmW-1:0] normal_z_o,
  output logic                   degenerate_o
);

  localparam logic [3:0] SClr  = 4'd0;
  localparam logic [3:0] SIdle = 4'd1;
  localparam logic [3:0] SRd1  = 4'd2;
  localparam logic [3:0] SRd2  = 4'd3;
  localparam logic [3:0] SRd3  = 4'd4;
  localparam logic [3:0] SXst  = 4'd5;
  localparam logic [3:0] SXwt  = 4'd6;
  localparam logic [3:0] SMag  = 4'd7;
  localparam logic [3:0] SSst  = 4'd8;
  localparam logic [3:0] SSwt  = 4'd9;
  localparam logic [3:0] SRst  = 4'd10;
  localparam logic [3:0] SRwt  = 4'd11;
  localparam logic [3:0] SDst  = 4'd12;
  localparam logic [3:0] SDwt  = 4'd13;
  localparam logic [3:0] SWrn  = 4'd14;
  localparam logic [3:0] SOut  = 4'd15;

  localparam logic signed [NrmW-1:0] NrmMax = NrmW'(1 << FracW);

  logic [3:0]             state_q, state_d;
  logic [OpW-1:0]         op_q;
  logic [IdxW-1:0]        idx_q [3];
  logic [2:0]             step_q;
  logic [IdxW-1:0]        clr_q;
  logic signed [PosW-1:0] p0_q [3];
  logic signed [EdgeW-1:0] a_q [3];
  logic signed [EdgeW-1:0] b_q [3];
  logic signed [CrossW-1:0] c_q [3];
  logic [MagW-1:0]        mag_q [3];
  logic                   neg_q [3];
  logic [SumW-1:0]        sum_q;
  logic [RootW-1:0]       root_q;
  logic signed [NrmW-1:0] n_q [3];
  logic                   degen_q;

  logic                   out_valid_q;
  logic signed [NrmW-1:0] out_n_q [3];
  logic                   out_degen_q;

  logic accept, out_load;
  logic [1:0] sel;

  assign sel        = step_q[1:0];
  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == SOut) && (!out_valid_q || out_ready_i);

  // ---------------- stores
  logic [3*PosW-1:0] pos_rdata;
  logic              pos_re;
  logic [IdxW-1:0]   pos_raddr;
  logic signed [PosW-1:0] pr [3];

  assign pos_re    = (accept && operation_i == OpTri) || state_q == SRd1 || state_q == SRd2;
  assign pos_raddr = (state_q == SIdle) ? corner0_index_i :
                     (state_q == SRd1)  ? idx_q[1] : idx_q[2];

  tfn_ram #(.Width(3 * PosW), .Depth(VertexCount)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (accept && operation_i == OpWrite),
    .waddr_i (corner0_index_i),
    .wdata_i ({pos_x_i, pos_y_i, pos_z_i}),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign pr[0] = pos_rdata[3*PosW-1 -: PosW];
  assign pr[1] = pos_rdata[2*PosW-1 -: PosW];
  assign pr[2] = pos_rdata[PosW-1:0];

  logic [3*NrmW-1:0] nrm_rdata;
  logic              nrm_we;
  logic [IdxW-1:0]   nrm_waddr;
  logic [3*NrmW-1:0] nrm_wdata;

  assign nrm_we    = (state_q == SClr) || (state_q == SWrn);
  assign nrm_waddr = (state_q == SClr) ? clr_q : idx_q[sel];
  assign nrm_wdata = (state_q == SClr) ? '0 : {n_q[0], n_q[1], n_q[2]};

  tfn_ram #(.Width(3 * NrmW), .Depth(VertexCount)) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (nrm_we),
    .waddr_i (nrm_waddr),
    .wdata_i (nrm_wdata),
    .re_i    (accept && operation_i == OpRead),
    .raddr_i (corner0_index_i),
    .rdata_o (nrm_rdata)
  );

  // ---------------- cross product operand selection
  logic signed [EdgeW-1:0] xa, xb, xa_neg, xb_neg;
  logic                    x_minus, x_neg;
  logic [1:0]              x_k;
  logic [EmagW-1:0]        xa_mag, xb_mag;

  always_comb begin
    unique case (step_q)
      3'd0:    begin xa = a_q[1]; xb = b_q[2]; x_minus = 1'b0; x_k = 2'd0; end
      3'd1:    begin xa = a_q[2]; xb = b_q[1]; x_minus = 1'b1; x_k = 2'd0; end
      3'd2:    begin xa = a_q[2]; xb = b_q[0]; x_minus = 1'b0; x_k = 2'd1; end
      3'd3:    begin xa = a_q[0]; xb = b_q[2]; x_minus = 1'b1; x_k = 2'd1; end
      3'd4:    begin xa = a_q[0]; xb = b_q[1]; x_minus = 1'b0; x_k = 2'd2; end
      3'd5:    begin xa = a_q[1]; xb = b_q[0]; x_minus = 1'b1; x_k = 2'd2; end
      default: begin xa = '0;     xb = '0;     x_minus = 1'b0; x_k = 2'd0; end
    endcase
    xa_neg = -xa;
    xb_neg = -xb;
    xa_mag = xa[EdgeW-1] ? xa_neg[EmagW-1:0] : xa[EmagW-1:0];
    xb_mag = xb[EdgeW-1] ? xb_neg[EmagW-1:0] : xb[EmagW-1:0];
    x_neg  = xa[EdgeW-1] ^ xb[EdgeW-1] ^ x_minus;
  end

  // ---------------- arithmetic units
  logic              mul_start, mul_done;
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_prod;

  assign mul_start = (state_q == SXst) || (state_q == SSst);
  assign mul_a = (state_q == SXst) ? {{(MulW-EmagW){1'b0}}, xa_mag} : mag_q[sel];
  assign mul_b = (state_q == SXst) ? {{(MulW-EmagW){1'b0}}, xb_mag} : mag_q[sel];

  tfn_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  logic             sqrt_done;
  logic [RootW-1:0] sqrt_root;

  tfn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == SRst),
    .rad_i   (sum_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  logic             div_done;
  logic [QuotW-1:0] div_quot;
  logic [NumW-1:0]  div_num;

  // rounded half up: add half the length before dividing
  assign div_num = (NumW'(mag_q[sel]) << FracW) + NumW'(root_q >> 1);

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == SDst),
    .num_i   (div_num),
    .den_i   (root_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------- combinational helpers
  logic signed [CrossW-1:0] x_term, x_pos;
  logic signed [NrmW-1:0]   q_ext, q_neg;
  logic [CmagW-1:0]         cabs [3];
  logic [CmagW-1:0]         c_or;
  logic [ShW-1:0]           sh;
  logic signed [CrossW-1:0] c_neg [3];
  logic [CmagW-1:0]         c_shift [3];
  logic                     c_zero;

  always_comb begin
    x_pos  = CrossW'(mul_prod);
    x_term = x_neg ? -x_pos : x_pos;
    q_ext  = NrmW'(div_quot);
    q_neg  = -q_ext;
    c_or   = '0;
    for (int k = 0; k < 3; k++) begin
      c_neg[k] = -c_q[k];
      cabs[k]  = c_q[k][CrossW-1] ? c_neg[k][CmagW-1:0] : c_q[k][CmagW-1:0];
      c_or     = c_or | cabs[k];
    end
    // least right shift bringing the largest magnitude below 2^MagW
    sh = '0;
    for (int k = 1; k <= int'(CmagW - MagW); k++) begin
      if ((c_or >> (MagW + k - 1)) != '0) begin
        sh = ShW'(k);
      end
    end
    for (int k = 0; k < 3; k++) begin
      c_shift[k] = cabs[k] >> sh;
    end
    c_zero = (c_or == '0);
  end

  // ---------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SClr:  if (clr_q == IdxW'(VertexCount - 1)) state_d = SIdle;
      SIdle: begin
        if (accept) begin
          state_d = (operation_i == OpTri) ? SRd1 : SOut;
        end
      end
      SRd1:  state_d = SRd2;
      SRd2:  state_d = SRd3;
      SRd3:  state_d = SXst;
      SXst:  state_d = SXwt;
      SXwt:  if (mul_done) state_d = (step_q == 3'd5) ? SMag : SXst;
      SMag:  state_d = c_zero ? SWrn : SSst;
      SSst:  state_d = SSwt;
      SSwt:  if (mul_done) state_d = (step_q == 3'd2) ? SRst : SSst;
      SRst:  state_d = SRwt;
      SRwt:  if (sqrt_done) state_d = SDst;
      SDst:  state_d = SDwt;
      SDwt:  if (div_done) state_d = (step_q == 3'd2) ? SWrn : SDst;
      SWrn:  if (step_q == 3'd2) state_d = SOut;
      SOut:  if (out_load) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SClr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == SRd3 || state_q == SMag || state_q == SRwt
          || (state_q == SDwt && div_done && step_q == 3'd2)) begin
        step_q <= '0;
      end else if ((state_q == SXwt && mul_done) || (state_q == SSwt && mul_done)
                   || (state_q == SDwt && div_done) || state_q == SWrn) begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      idx_q[0] <= corner0_index_i;
      idx_q[1] <= corner1_index_i;
      idx_q[2] <= corner2_index_i;
    end
    if (state_q == SRd1) begin
      for (int k = 0; k < 3; k++) p0_q[k] <= pr[k];
    end
    if (state_q == SRd2) begin
      for (int k = 0; k < 3; k++) a_q[k] <= EdgeW'(pr[k]) - EdgeW'(p0_q[k]);
    end
    if (state_q == SRd3) begin
      for (int k = 0; k < 3; k++) begin
        b_q[k] <= EdgeW'(pr[k]) - EdgeW'(p0_q[k]);
        c_q[k] <= '0;
      end
    end
    if (state_q == SXwt && mul_done) begin
      c_q[x_k] <= c_q[x_k] + x_term;
    end
    if (state_q == SMag) begin
      sum_q   <= '0;
      degen_q <= c_zero;
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= c_shift[k][MagW-1:0];
        neg_q[k] <= c_q[k][CrossW-1];
        n_q[k]   <= '0;
      end
    end
    if (state_q == SSwt && mul_done) begin
      sum_q <= sum_q + SumW'(mul_prod);
    end
    if (state_q == SRwt && sqrt_done) begin
      root_q <= sqrt_root;
    end
    if (state_q == SDwt && div_done) begin
      n_q[sel] <= neg_q[sel] ? q_neg : q_ext;
    end
    if (out_load) begin
      unique case (op_q)
        OpTri: begin
          for (int k = 0; k < 3; k++) out_n_q[k] <= n_q[k];
          out_degen_q <= degen_q;
        end
        OpRead: begin
          out_n_q[0]  <= nrm_rdata[3*NrmW-1 -: NrmW];
          out_n_q[1]  <= nrm_rdata[2*NrmW-1 -: NrmW];
          out_n_q[2]  <= nrm_rdata[NrmW-1:0];
          out_degen_q <= 1'b0;
        end
        OpWrite: begin
          for (int k = 0; k < 3; k++) out_n_q[k] <= '0;
          out_degen_q <= 1'b0;
        end
        default: begin
          for (int k = 0; k < 3; k++) out_n_q[k] <= '0;
          out_degen_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_n_q[0];
  assign normal_y_o   = out_n_q[1];
  assign normal_z_o   = out_n_q[2];
  assign degenerate_o = out_degen_q;

  // ---------------- assertions
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate item with nonzero normal");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while previous one still in work");

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == SXwt || state_q == SSwt)
    else $error("multiplier finished outside a product wait");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o <= NrmMax && normal_x_o >= -NrmMax
                 && normal_y_o <= NrmMax && normal_y_o >= -NrmMax
                 && normal_z_o <= NrmMax && normal_z_o >= -NrmMax)
    else $error("normal component beyond unit range");

endmodule

// ===== verif/tfn_checker.sv =====
// Face normal predictor and result checker for the triangle face normal engine.
module tfn_checker import tfn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [OpW-1:0]         operation_i,
  input  logic [IdxW-1:0]        corner0_index_i,
  input  logic [IdxW-1:0]        corner1_index_i,
  input  logic [IdxW-1:0]        corner2_index_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic signed [NrmW-1:0] normal_x_i,
  input  logic signed [NrmW-1:0] normal_y_i,
  input  logic signed [NrmW-1:0] normal_z_i,
  input  logic                   degenerate_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
    logic signed [NrmW-1:0] nz;
    logic                   degen;
  } normal_t;

  longint         pos_mem [VertexCount][3];
  logic signed [NrmW-1:0] nrm_mem [VertexCount][3];
  normal_t        normal_q[$];

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Runs one item against the shadow stores and returns the expected result.
  function automatic normal_t face_normal(logic [OpW-1:0] op, logic [IdxW-1:0] c0,
      logic [IdxW-1:0] c1, logic [IdxW-1:0] c2, logic signed [PosW-1:0] px,
      logic signed [PosW-1:0] py, logic signed [PosW-1:0] pz);
    normal_t r;
    longint a[3], b[3], c[3];
    longint unsigned mag[3], mx, s, len, q;
    logic neg[3];
    longint v;
    logic [IdxW-1:0] ix[3];
    r = '0;
    ix[0] = c0; ix[1] = c1; ix[2] = c2;
    if (op == OpWrite) begin
      pos_mem[c0][0] = px;
      pos_mem[c0][1] = py;
      pos_mem[c0][2] = pz;
    end else if (op == OpRead) begin
      r.nx = nrm_mem[c0][0];
      r.ny = nrm_mem[c0][1];
      r.nz = nrm_mem[c0][2];
    end else if (op == OpTri) begin
      for (int k = 0; k < 3; k++) begin
        a[k] = pos_mem[c1][k] - pos_mem[c0][k];
        b[k] = pos_mem[c2][k] - pos_mem[c0][k];
      end
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        neg[k] = c[k] < 0;
        mag[k] = neg[k] ? -c[k] : c[k];
        if (mag[k] > mx) mx = mag[k];
      end
      while (mx >= (64'd1 << 31)) begin
        mx = mx >> 1;
        for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      end
      s = 0;
      for (int k = 0; k < 3; k++) s = s + mag[k] * mag[k];
      if (s == 0) begin
        r.degen = 1'b1;
      end else begin
        len = floor_sqrt(s);
        for (int k = 0; k < 3; k++) begin
          q = ((mag[k] << FracW) + (len >> 1)) / len;
          v = neg[k] ? -longint'(q) : longint'(q);
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          if (k == 0) r.nx = v[NrmW-1:0];
          else if (k == 1) r.ny = v[NrmW-1:0];
          else r.nz = v[NrmW-1:0];
        end
      end
      for (int k = 0; k < 3; k++) begin
        nrm_mem[ix[k]][0] = r.nx;
        nrm_mem[ix[k]][1] = r.ny;
        nrm_mem[ix[k]][2] = r.nz;
      end
    end
    return r;
  endfunction

  assign pending_o = normal_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    normal_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      normal_q.delete();
      for (int i = 0; i < VertexCount; i++)
        for (int k = 0; k < 3; k++) begin
          pos_mem[i][k] = 0;
          nrm_mem[i][k] = '0;
        end
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected result %h %h %h %b", $time, normal_x_i, normal_y_i,
                   normal_z_i, degenerate_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = normal_q.pop_front();
          if (want.nx !== normal_x_i || want.ny !== normal_y_i ||
              want.nz !== normal_z_i || want.degen !== degenerate_i) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d dg=%b actual x=%0d y=%0d z=%0d dg=%b",
                     $time, want.nx, want.ny, want.nz, want.degen,
                     normal_x_i, normal_y_i, normal_z_i, degenerate_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        normal_q.push_back(face_normal(operation_i, corner0_index_i, corner1_index_i,
                                       corner2_index_i, pos_x_i, pos_y_i, pos_z_i));
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Stimulus and verdict for the triangle face normal engine.
module tb_top;
  import tfn_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int StallLimit = 6000;
  localparam int HoldCycles = 800;

  logic clk_i, rst_ni;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [OpW-1:0] operation;
  logic [IdxW-1:0] c0_idx, c1_idx, c2_idx;
  logic signed [PosW-1:0] pos_x, pos_y, pos_z;
  logic signed [NrmW-1:0] nrm_x, nrm_y, nrm_z;
  logic degenerate;
  logic in_fire;
  logic quiet, hold_req, hold_done;
  int fail_count, pending, stall_cnt, hold_cnt;
  int op_cnt[4];
  int written_q[$];
  bit written[VertexCount];

  triangle_face_normal_engine uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .corner0_index_i(c0_idx), .corner1_index_i(c1_idx),
    .corner2_index_i(c2_idx), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .normal_x_o(nrm_x), .normal_y_o(nrm_y), .normal_z_o(nrm_z), .degenerate_o(degenerate)
  );

  tfn_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .operation_i(operation),
    .corner0_index_i(c0_idx), .corner1_index_i(c1_idx), .corner2_index_i(c2_idx),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .normal_x_i(nrm_x), .normal_y_i(nrm_y), .normal_z_i(nrm_z), .degenerate_i(degenerate),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_fire <= in_valid && in_ready;
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_cnt = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        out_ready = 1'b0;
        hold_cnt--;
      end else begin
        out_ready = quiet || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic send(logic [OpW-1:0] op, int a, int b, int c,
                      int x, int y, int z);
    int gap;
    if (!quiet && $urandom_range(99) < 24) begin
      gap = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  = 1'b1;
    operation = op;
    c0_idx = IdxW'(a); c1_idx = IdxW'(b); c2_idx = IdxW'(c);
    pos_x = PosW'(x); pos_y = PosW'(y); pos_z = PosW'(z);
    if (op == OpWrite && !written[a]) begin
      written[a] = 1'b1;
      written_q.push_back(a);
    end
    op_cnt[op]++;
    do @(negedge clk_i); while (!in_fire);
  endtask

  function automatic int any_written();
    return written_q[$urandom_range(written_q.size() - 1)];
  endfunction

  function automatic int rand_pos();
    int r;
    r = $urandom_range(9);
    if (r == 0) return ($urandom_range(1)) ? 32767 : -32768;
    if (r < 5) return $signed(16'($urandom));
    return int'($urandom_range(1024)) - 512;
  endfunction

  initial begin
    int op_sel, idx, t0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    operation = OpWrite;
    c0_idx = '0; c1_idx = '0; c2_idx = '0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every operation, degenerate and unused code
    send(OpRead, 500, 0, 0, 0, 0, 0);
    send(OpWrite, 0, 0, 0, 0, 0, 0);
    send(OpWrite, 1, 0, 0, 256, 0, 0);
    send(OpWrite, 2, 0, 0, 0, 256, 0);
    send(OpTri, 0, 1, 2, 0, 0, 0);
    send(OpRead, 0, 0, 0, 0, 0, 0);
    send(OpRead, 2, 0, 0, 0, 0, 0);
    send(OpWrite, 1023, 1023, 1023, 32767, -32768, 32767);
    send(OpWrite, 3, 0, 0, -32768, 32767, -32768);
    send(OpWrite, 4, 0, 0, 32767, 32767, -32768);
    send(OpTri, 1023, 3, 4, 0, 0, 0);
    send(OpRead, 1023, 0, 0, 0, 0, 0);
    send(OpTri, 0, 0, 1, 0, 0, 0);
    send(OpRead, 1, 0, 0, 0, 0, 0);
    send(OpWrite, 5, 0, 0, 512, 512, 512);
    send(OpTri, 0, 5, 5, 0, 0, 0);
    send(OpUnused, 1023, 1023, 1023, -1, -1, -1);
    send(OpRead, 5, 0, 0, 0, 0, 0);
    send(OpTri, 3, 1023, 4, 0, 0, 0);
    send(OpRead, 4, 1023, 1023, -1, -1, -1);

    for (int n = 0; n < 1300; n++) begin
      quiet = (n >= 500 && n < 750);
      if (n == 300) hold_req = 1'b1;
      op_sel = $urandom_range(99);
      idx = ($urandom_range(3) == 0) ? $urandom_range(VertexCount - 1)
                                     : $urandom_range(31);
      t0 = any_written();
      if (op_sel < 35)
        send(OpWrite, idx, $urandom_range(1023), $urandom_range(1023),
             rand_pos(), rand_pos(), rand_pos());
      else if (op_sel < 70)
        send(OpTri, t0, any_written(),
             ($urandom_range(15) == 0) ? t0 : any_written(), 0, 0, 0);
      else if (op_sel < 95)
        send(OpRead, idx, $urandom_range(1023), $urandom_range(1023),
             rand_pos(), rand_pos(), rand_pos());
      else
        send(OpUnused, idx, $urandom_range(1023), $urandom_range(1023),
             rand_pos(), rand_pos(), rand_pos());
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    $display("covered %0d writes, %0d triangles, %0d reads, %0d unused-code items",
             op_cnt[OpWrite], op_cnt[OpTri], op_cnt[OpRead], op_cnt[OpUnused]);
    $display("with random gaps on both sides and one long output hold-off");
    if (fail_count == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
